>>> design/cle_pkg.sv
// shared types, constants and codes for the cursor line editor
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

  localparam int CAPACITY  = 4096;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 13;
  localparam int POS_W     = 12;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] OP_LEFT   = 3'd0;
  localparam logic [2:0] OP_RIGHT  = 3'd1;
  localparam logic [2:0] OP_BACK   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EDGE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    CMD_LEFT,
    CMD_RIGHT,
    CMD_BACK,
    CMD_INSERT,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOVE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       char_in;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           char_out;
    logic [1:0]           status;
    logic                 is_last;
    logic [OUT_CNT_W-1:0] text_length;
    logic [OUT_CNT_W-1:0] cursor_pos;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
  } cmd_t;

  // queue status and read side as seen by the back end
  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_rd_t;

endpackage
`default_nettype wire

>>> design/cle_front.sv
// front end: accepts command beats and decodes them into queue entries
`timescale 1ns / 1ps
`default_nettype none
module cle_front (
  input  wire  cle_pkg::in_item_t cmd,
  input  wire                     push,
  input  wire                     q_full,
  output logic                    full,
  output logic                    q_wr,
  output cle_pkg::cmd_t           q_wdata
);
  import cle_pkg::*;

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_wdata.ch  = cmd.char_in;
    q_wdata.pos = cmd.position;
    unique case (cmd.opcode)
      OP_LEFT:   q_wdata.kind = CMD_LEFT;
      OP_RIGHT:  q_wdata.kind = CMD_RIGHT;
      OP_BACK:   q_wdata.kind = CMD_BACK;
      OP_INSERT: q_wdata.kind = CMD_INSERT;
      OP_READ:   q_wdata.kind = CMD_READ;
      default:   q_wdata.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> design/cle_cmd_fifo.sv
// short command queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module cle_cmd_fifo (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr,
  input  wire cle_pkg::cmd_t wdata,
  input  wire                rd,
  output logic               q_full,
  output cle_pkg::q_rd_t     q_out
);
  import cle_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign q_full      = (count == QCNT_W'(QDEPTH));
  assign q_out.empty = (count == '0);
  assign q_out.head  = entries[rd_ptr];

  assign do_wr = wr && !q_full;
  assign do_rd = rd && !q_out.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> design/cle_back.sv
// back end: gap buffer store, cursor counts and the result register
`timescale 1ns / 1ps
`default_nettype none
module cle_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire cle_pkg::q_rd_t q_in,
  output logic                q_rd,
  output cle_pkg::out_item_t  res,
  output logic                empty,
  input  wire                 pop
);
  import cle_pkg::*;

  logic [7:0] text_store [CAPACITY];

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0] left_count;
  logic [CNT_W-1:0] right_count;
  logic [CNT_W-1:0] left_count_next;
  logic [CNT_W-1:0] right_count_next;
  logic [CNT_W-1:0] text_len;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] right_idx;

  cmd_kind_t cur_kind;
  logic      last_hold;
  logic      last_hold_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_re;
  logic [7:0]        rdata;

  logic      res_valid;
  logic      res_load;
  out_item_t res_next;
  logic [1:0] st_next;
  logic [7:0] ch_next;
  logic       last_next;

  logic out_free;
  logic take;

  assign text_len = left_count + right_count;
  assign pos_ext  = CNT_W'(q_in.head.pos);
  // text position past the cursor maps into the high end of the store
  assign right_idx = CNT_W'(CAPACITY) - text_len + pos_ext;

  assign out_free = !res_valid || pop;
  assign take     = (state == BK_IDLE) && !q_in.empty && out_free;
  assign q_rd     = take;
  assign empty    = !res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          priority if (q_in.head.kind == CMD_LEFT && left_count != '0) begin
            state_next = BK_MOVE;
          end else if (q_in.head.kind == CMD_RIGHT && right_count != '0) begin
            state_next = BK_MOVE;
          end else if (q_in.head.kind == CMD_READ && pos_ext < text_len) begin
            state_next = BK_READ;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_MOVE: state_next = BK_IDLE;
      BK_READ: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = ADDR_W'(left_count);
    mem_wdata        = q_in.head.ch;
    mem_re           = 1'b0;
    mem_raddr        = ADDR_W'(left_count);
    left_count_next  = left_count;
    right_count_next = right_count;
    last_hold_next   = last_hold;
    res_load         = 1'b0;
    st_next          = ST_DONE;
    ch_next          = '0;
    last_next        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          unique case (q_in.head.kind)
            CMD_LEFT: begin
              if (left_count == '0) begin
                res_load = 1'b1;
                st_next  = ST_EDGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(left_count - 1'b1);
              end
            end
            CMD_RIGHT: begin
              if (right_count == '0) begin
                res_load = 1'b1;
                st_next  = ST_EDGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(CNT_W'(CAPACITY) - right_count);
              end
            end
            CMD_BACK: begin
              res_load = 1'b1;
              if (left_count == '0) begin
                st_next = ST_EDGE;
              end else begin
                left_count_next = left_count - 1'b1;
              end
            end
            CMD_INSERT: begin
              res_load = 1'b1;
              if (text_len >= CNT_W'(CAPACITY)) begin
                st_next = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                left_count_next = left_count + 1'b1;
              end
            end
            CMD_READ: begin
              if (pos_ext >= text_len) begin
                res_load = 1'b1;
                st_next  = ST_RANGE;
              end else begin
                mem_re         = 1'b1;
                mem_raddr      = (pos_ext < left_count) ? ADDR_W'(pos_ext)
                                                        : ADDR_W'(right_idx);
                last_hold_next = (pos_ext + 1'b1 == text_len);
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      BK_MOVE: begin
        res_load  = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = rdata;
        if (cur_kind == CMD_LEFT) begin
          mem_waddr        = ADDR_W'(CNT_W'(CAPACITY - 1) - right_count);
          left_count_next  = left_count - 1'b1;
          right_count_next = right_count + 1'b1;
        end else begin
          mem_waddr        = ADDR_W'(left_count);
          left_count_next  = left_count + 1'b1;
          right_count_next = right_count - 1'b1;
        end
      end
      BK_READ: begin
        res_load  = 1'b1;
        ch_next   = rdata;
        last_next = last_hold;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_next.char_out    = ch_next;
    res_next.status      = st_next;
    res_next.is_last     = last_next;
    res_next.text_length = OUT_CNT_W'(left_count_next + right_count_next);
    res_next.cursor_pos  = OUT_CNT_W'(left_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      left_count  <= '0;
      right_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      left_count  <= left_count_next;
      right_count <= right_count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_hold <= last_hold_next;
    if (take) begin
      cur_kind <= q_in.head.kind;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= text_store[mem_raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/cursor_line_editor_top.sv
// top level of the cursor line editor
// Usage: commands enter as beats on cmd with push/full; a beat is taken at a
// rising edge with push high and full low. Results leave on res with
// empty/pop; the oldest result stands on res while empty is low and is taken
// at an edge with pop high and empty low. Exactly one result per command.
// A backspace, insert, failed command or unused opcode loads its result
// register when the back end takes the command from the queue; a cursor
// move or a successful read first goes through the registered store read
// and then writes or captures in the BK_MOVE or BK_READ state.
// Throughput: one command per cycle for backspace and insert while results
// are popped; a move or read holds the back end sequencer out of BK_IDLE.
// A two-entry command queue lets push continue while a result waits; full
// follows the queue alone: it rises once both entries are occupied and falls
// when the back end takes an entry. Stalling on pop never loses a result.
// Reset (rst, synchronous): text empty, cursor at zero, queue and result
// register empty. No clearing pass: store entries are read only after write.
`timescale 1ns / 1ps
`default_nettype none
module cursor_line_editor_top (
  input  wire                     clk,
  input  wire                     rst,
  input  wire  cle_pkg::in_item_t cmd,
  input  wire                     push,
  output logic                    full,
  output cle_pkg::out_item_t      res,
  output logic                    empty,
  input  wire                     pop
);
  import cle_pkg::*;

  logic  q_full;
  logic  q_wr;
  cmd_t  q_wdata;
  logic  q_rd;
  q_rd_t q_out;

  cle_front u_front (
    .cmd     (cmd),
    .push    (push),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  cle_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .rd     (q_rd),
    .q_full (q_full),
    .q_out  (q_out)
  );

  cle_back u_back (
    .clk   (clk),
    .rst   (rst),
    .q_in  (q_out),
    .q_rd  (q_rd),
    .res   (res),
    .empty (empty),
    .pop   (pop)
  );

endmodule
`default_nettype wire
